// ----- rtl/core/rtlex_pkg.sv -----
// shared types, codes and helpers for the regex token lexer
`timescale 1ns / 1ps

package rtlex_pkg;

	localparam int MAX_DEPTH = 255;
	localparam logic [15:0] POS_CAP = 16'hFFFF;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_UNION = 8'h7C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [1:0] ERR_INVALID_CHAR = 2'd0;
	localparam logic [1:0] ERR_INVALID_ESC = 2'd1;
	localparam logic [1:0] ERR_UNEXPECTED_END = 2'd2;

	typedef enum logic [3:0] {
		K_CHAR = 4'd0,
		K_STAR = 4'd1,
		K_PLUS = 4'd2,
		K_QUEST = 4'd3,
		K_LPAREN = 4'd4,
		K_RPAREN = 4'd5,
		K_UNION = 4'd6,
		K_ESC_OPEN = 4'd7,
		K_ESC_CHAR = 4'd8,
		K_END = 4'd9,
		K_ERROR = 4'd10
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] value;
		logic [1:0] err_code;
		logic [15:0] err_pos;
		logic final_res;
	} res_t;

	// results of one byte, written into the result queue together
	typedef struct packed {
		logic [1:0] n;
		res_t r0;
		res_t r1;
	} res_wr_t;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

// ----- rtl/core/rtlex_if.sv -----
// byte and token channel interfaces
`timescale 1ns / 1ps

interface rtlex_byte_if;
	logic valid;
	logic ready;
	logic [7:0] ch;
	logic is_last;

	modport source (output valid, output ch, output is_last, input ready);
	modport sink (input valid, input ch, input is_last, output ready);
endinterface

interface rtlex_tok_if;
	logic valid;
	logic ready;
	logic [3:0] kind;
	logic [7:0] value;
	logic [1:0] err_code;
	logic [15:0] err_pos;
	logic final_res;

	modport source (output valid, output kind, output value, output err_code,
		output err_pos, output final_res, input ready);
	modport sink (input valid, input kind, input value, input err_code,
		input err_pos, input final_res, output ready);
endinterface

// ----- rtl/core/rtlex_core.sv -----
// input stage register and per-byte token classification with lexer state
`timescale 1ns / 1ps

module rtlex_core (
	input logic clk,
	input logic arst_n,
	input logic acc,
	input logic [7:0] ch,
	input logic is_last,
	output logic s1_valid,
	output rtlex_pkg::res_wr_t wr
);

	typedef struct packed {
		logic [7:0] depth;
		logic [15:0] pos;
		rtlex_pkg::kind_t prev;
		logic have;
		logic esc;
		logic failed;
		logic [15:0] upos;
	} st_t;

	localparam st_t ST_RESET = '{
		depth: 8'd0, pos: 16'd0, prev: rtlex_pkg::K_CHAR, have: 1'b0,
		esc: 1'b0, failed: 1'b0, upos: 16'd0
	};

	logic valid_s1;
	logic [7:0] ch_s1;
	logic last_s1;
	st_t st_q;
	st_t st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ch_s1 <= ch;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (valid_s1) begin
			st_q <= st_d;
		end
	end

	always_comb begin
		logic err;
		logic [1:0] ecode;
		logic [15:0] epos;
		logic adv;
		st_d = st_q;
		wr = '0;
		err = 1'b0;
		ecode = rtlex_pkg::ERR_INVALID_CHAR;
		epos = st_q.pos;
		adv = 1'b0;
		wr.r0.kind = rtlex_pkg::K_CHAR;
		wr.r1.kind = rtlex_pkg::K_CHAR;
		if (st_q.failed) begin
			if (last_s1) begin
				st_d = ST_RESET;
			end
		end else if (st_q.esc && rtlex_pkg::is_alnum(ch_s1)) begin
			wr.r0.kind = rtlex_pkg::K_ESC_CHAR;
			wr.r0.value = ch_s1;
			wr.n = 2'd1;
			st_d.prev = rtlex_pkg::K_ESC_CHAR;
			st_d.have = 1'b1;
			adv = 1'b1;
		end else begin
			st_d.esc = 1'b0;
			wr.r0.value = ch_s1;
			priority if (st_q.have && st_q.prev == rtlex_pkg::K_UNION &&
				ch_s1 == rtlex_pkg::CH_RPAREN) begin
				// the union before this paren was already sent
				err = 1'b1;
				epos = st_q.upos;
			end else if (rtlex_pkg::is_alnum(ch_s1)) begin
				wr.r0.kind = rtlex_pkg::K_CHAR;
			end else if (ch_s1 == rtlex_pkg::CH_STAR) begin
				wr.r0.kind = rtlex_pkg::K_STAR;
			end else if (ch_s1 == rtlex_pkg::CH_PLUS) begin
				wr.r0.kind = rtlex_pkg::K_PLUS;
			end else if (ch_s1 == rtlex_pkg::CH_QUEST) begin
				wr.r0.kind = rtlex_pkg::K_QUEST;
			end else if (ch_s1 == rtlex_pkg::CH_LPAREN) begin
				if (st_q.depth >= 8'(rtlex_pkg::MAX_DEPTH)) begin
					err = 1'b1;
				end else begin
					wr.r0.kind = rtlex_pkg::K_LPAREN;
					st_d.depth = st_q.depth + 8'd1;
				end
			end else if (ch_s1 == rtlex_pkg::CH_RPAREN) begin
				if (st_q.depth == 8'd0) begin
					err = 1'b1;
				end else begin
					wr.r0.kind = rtlex_pkg::K_RPAREN;
					st_d.depth = st_q.depth - 8'd1;
				end
			end else if (ch_s1 == rtlex_pkg::CH_UNION) begin
				if (!st_q.have || st_q.prev == rtlex_pkg::K_UNION ||
					st_q.prev == rtlex_pkg::K_LPAREN) begin
					err = 1'b1;
				end else begin
					wr.r0.kind = rtlex_pkg::K_UNION;
					st_d.upos = st_q.pos;
				end
			end else if (ch_s1 == rtlex_pkg::CH_BSLASH) begin
				if (last_s1) begin
					err = 1'b1;
					ecode = rtlex_pkg::ERR_INVALID_ESC;
				end else begin
					wr.r0.kind = rtlex_pkg::K_ESC_OPEN;
					st_d.esc = 1'b1;
				end
			end else begin
				err = 1'b1;
			end

			wr.n = 2'd1;
			if (err) begin
				wr.r0.kind = rtlex_pkg::K_ERROR;
				wr.r0.value = 8'd0;
				wr.r0.err_code = ecode;
				wr.r0.err_pos = epos;
				wr.r0.final_res = 1'b1;
				st_d = st_q;
				st_d.failed = 1'b1;
				if (last_s1) begin
					st_d = ST_RESET;
				end
			end else begin
				st_d.prev = wr.r0.kind;
				st_d.have = 1'b1;
				adv = 1'b1;
			end
		end

		if (adv) begin
			if (st_q.pos != rtlex_pkg::POS_CAP) begin
				st_d.pos = st_q.pos + 16'd1;
			end
			if (last_s1) begin
				wr.n = 2'd2;
				wr.r1.final_res = 1'b1;
				if (st_d.depth != 8'd0) begin
					wr.r1.kind = rtlex_pkg::K_ERROR;
					wr.r1.err_code = rtlex_pkg::ERR_UNEXPECTED_END;
					wr.r1.err_pos = st_d.pos;
				end else begin
					wr.r1.kind = rtlex_pkg::K_END;
				end
				st_d = ST_RESET;
			end
		end

		if (!valid_s1) begin
			wr.n = 2'd0;
		end
	end

	assign s1_valid = valid_s1;

endmodule

// ----- rtl/core/rtlex_fifo.sv -----
// result queue taking up to two tokens per cycle, one out per beat
`timescale 1ns / 1ps

module rtlex_fifo (
	input logic clk,
	input logic arst_n,
	input rtlex_pkg::res_wr_t wr,
	input logic pop,
	output logic not_empty,
	output logic [rtlex_pkg::FIFO_AW:0] count,
	output rtlex_pkg::res_t head
);

	localparam int AW = rtlex_pkg::FIFO_AW;

	rtlex_pkg::res_t mem_q [rtlex_pkg::FIFO_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0] count_q;
	logic [AW-1:0] wr_ptr_p1;

	assign wr_ptr_p1 = wr_ptr_q + AW'(1);

	always_ff @(posedge clk) begin
		if (wr.n != 2'd0) begin
			mem_q[wr_ptr_q] <= wr.r0;
		end
		if (wr.n == 2'd2) begin
			mem_q[wr_ptr_p1] <= wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(wr.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + (AW + 1)'(wr.n) - (AW + 1)'(pop);
		end
	end

	assign not_empty = (count_q != '0);
	assign count = count_q;
	assign head = mem_q[rd_ptr_q];

endmodule

// ----- rtl/core/regex_token_lexer_unit.sv -----
// top level of the regex token lexer
`timescale 1ns / 1ps

// Regex token lexer. One regex byte is taken per beat on bytes, with is_last on
// its final byte, and tokens leave one per beat on tokens. A byte is accepted
// every cycle as long as the 8-entry result queue has room for the byte in
// flight plus this one; each byte normally yields one token, and a clean final
// byte yields two (its token and the end or unclosed-paren beat), so a clean
// regex of N bytes needs N+1 output beats. A byte's first token can be offered
// only once the byte has passed the input stage register and its classified
// token has been written into the result queue. After an error the block sends
// nothing more until the final byte of that regex, then starts clean.
module regex_token_lexer_unit (
	input logic clk,
	input logic arst_n,
	rtlex_byte_if.sink bytes,
	rtlex_tok_if.source tokens
);

	logic acc;
	logic pop;
	logic not_empty;
	rtlex_pkg::res_wr_t wr;
	rtlex_pkg::res_t head;
	logic [rtlex_pkg::FIFO_AW:0] q_count;
	logic s1_valid;
	logic [rtlex_pkg::FIFO_AW+1:0] pending;

	// slots already spoken for: queue contents plus two for the byte in stage one
	assign pending = (rtlex_pkg::FIFO_AW + 2)'(q_count) +
		(s1_valid ? (rtlex_pkg::FIFO_AW + 2)'(2) : '0);
	assign bytes.ready = (pending <= (rtlex_pkg::FIFO_AW + 2)'(rtlex_pkg::FIFO_DEPTH - 2));
	assign acc = bytes.valid && bytes.ready;

	rtlex_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.ch(bytes.ch),
		.is_last(bytes.is_last),
		.s1_valid(s1_valid),
		.wr(wr)
	);

	rtlex_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.pop(pop),
		.not_empty(not_empty),
		.count(q_count),
		.head(head)
	);

	assign pop = not_empty && tokens.ready;
	assign tokens.valid = not_empty;
	assign tokens.kind = head.kind;
	assign tokens.value = head.value;
	assign tokens.err_code = head.err_code;
	assign tokens.err_pos = head.err_pos;
	assign tokens.final_res = head.final_res;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= (rtlex_pkg::FIFO_AW + 1)'(rtlex_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_byte_reaches_stage: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> s1_valid)
		else $error("accepted byte missing from stage one");

	a_final_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid |-> (tokens.final_res ==
			(tokens.kind == rtlex_pkg::K_ERROR || tokens.kind == rtlex_pkg::K_END)))
		else $error("final flag does not match token kind");

endmodule

// ----- bench/testbench.sv -----
// self-checking testbench for the regex token lexer
`timescale 1ns / 1ps

module testbench;
	import rtlex_pkg::*;

	localparam int LIMIT = 2000000;
	localparam int RANDOM_BYTES = 1000;
	localparam int LONG_BYTES = 300;
	localparam int REPORT_CAP = 100;
	localparam logic [1:0] CODE_NONE = 2'd0;
	localparam res_t NO_TOK = '0;

	// one byte beat with, optionally, the tokens it must produce typed in
	typedef struct packed {
		logic [7:0] ch;
		logic last;
		logic typed;
		logic [1:0] n;
		res_t r0;
		res_t r1;
	} lex_row_t;

	logic clk;
	logic arst_n;

	rtlex_byte_if bytes_ch ();
	rtlex_tok_if tok_ch ();

	regex_token_lexer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes_ch),
		.tokens(tok_ch)
	);

	lex_row_t directed_rows[$];
	lex_row_t pending_rows[$];
	res_t expected_tokens[$];
	int mismatches = 0;
	int cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	// predicted lexer state
	logic [7:0] p_depth;
	logic [15:0] p_pos;
	kind_t p_prev;
	logic p_have;
	logic p_esc;
	logic p_failed;
	logic [15:0] p_union;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic is_word(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic res_t tok(input kind_t k, input logic [7:0] v, input logic [1:0] code,
		input logic [15:0] pos, input logic fin);
		res_t t;
		t.kind = k;
		t.value = v;
		t.err_code = code;
		t.err_pos = pos;
		t.final_res = fin;
		return t;
	endfunction

	function automatic lex_row_t plain_row(input logic [7:0] c, input logic l);
		lex_row_t r;
		r = '0;
		r.ch = c;
		r.last = l;
		return r;
	endfunction

	function automatic lex_row_t typed_row(input logic [7:0] c, input logic l,
		input logic [1:0] n, input res_t r0, input res_t r1);
		lex_row_t r;
		r = plain_row(c, l);
		r.typed = 1'b1;
		r.n = n;
		r.r0 = r0;
		r.r1 = r1;
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_word();
		int r;
		r = $urandom_range(0, 61);
		if (r < 10)
			return 8'("0" + r);
		if (r < 36)
			return 8'("A" + r - 10);
		return 8'("a" + r - 36);
	endfunction

	task automatic lex_clear();
		p_depth = '0;
		p_pos = '0;
		p_prev = K_CHAR;
		p_have = 1'b0;
		p_esc = 1'b0;
		p_failed = 1'b0;
		p_union = '0;
	endtask

	task automatic emit(input kind_t k, input logic [7:0] v, input logic [1:0] code,
		input logic [15:0] pos, input logic fin, input logic keep);
		if (keep)
			expected_tokens.push_back(tok(k, v, code, pos, fin));
	endtask

	// tokens caused by one accepted byte
	task automatic lex_byte(input logic [7:0] c, input logic l, input logic keep);
		logic err;
		logic esc_run;
		logic [1:0] code;
		logic [15:0] where;
		err = 1'b0;
		esc_run = 1'b0;
		code = ERR_INVALID_CHAR;
		where = p_pos;
		if (p_failed) begin
			if (l)
				lex_clear();
			return;
		end
		if (p_esc) begin
			if (is_word(c)) begin
				emit(K_ESC_CHAR, c, CODE_NONE, '0, 1'b0, keep);
				p_prev = K_ESC_CHAR;
				p_have = 1'b1;
				esc_run = 1'b1;
			end else begin
				p_esc = 1'b0;
			end
		end
		if (!esc_run) begin
			if (p_have && p_prev == K_UNION && c == CH_RPAREN) begin
				// an empty branch is blamed on its union
				err = 1'b1;
				where = p_union;
			end else if (is_word(c)) begin
				emit(K_CHAR, c, CODE_NONE, '0, 1'b0, keep);
				p_prev = K_CHAR;
			end else if (c == CH_STAR) begin
				emit(K_STAR, c, CODE_NONE, '0, 1'b0, keep);
				p_prev = K_STAR;
			end else if (c == CH_PLUS) begin
				emit(K_PLUS, c, CODE_NONE, '0, 1'b0, keep);
				p_prev = K_PLUS;
			end else if (c == CH_QUEST) begin
				emit(K_QUEST, c, CODE_NONE, '0, 1'b0, keep);
				p_prev = K_QUEST;
			end else if (c == CH_LPAREN) begin
				if (p_depth >= MAX_DEPTH) begin
					err = 1'b1;
				end else begin
					emit(K_LPAREN, c, CODE_NONE, '0, 1'b0, keep);
					p_prev = K_LPAREN;
					p_depth++;
				end
			end else if (c == CH_RPAREN) begin
				if (p_depth == 0) begin
					err = 1'b1;
				end else begin
					emit(K_RPAREN, c, CODE_NONE, '0, 1'b0, keep);
					p_prev = K_RPAREN;
					p_depth--;
				end
			end else if (c == CH_UNION) begin
				if (!p_have || p_prev == K_UNION || p_prev == K_LPAREN) begin
					err = 1'b1;
				end else begin
					emit(K_UNION, c, CODE_NONE, '0, 1'b0, keep);
					p_prev = K_UNION;
					p_union = p_pos;
				end
			end else if (c == CH_BSLASH) begin
				if (l) begin
					err = 1'b1;
					code = ERR_INVALID_ESC;
				end else begin
					emit(K_ESC_OPEN, c, CODE_NONE, '0, 1'b0, keep);
					p_prev = K_ESC_OPEN;
					p_esc = 1'b1;
				end
			end else begin
				err = 1'b1;
			end
			if (err) begin
				emit(K_ERROR, '0, code, where, 1'b1, keep);
				if (l)
					lex_clear();
				else
					p_failed = 1'b1;
				return;
			end
			p_have = 1'b1;
		end
		if (p_pos != POS_CAP)
			p_pos++;
		if (l) begin
			if (p_depth != 0)
				emit(K_ERROR, '0, ERR_UNEXPECTED_END, p_pos, 1'b1, keep);
			else
				emit(K_END, '0, CODE_NONE, '0, 1'b1, keep);
			lex_clear();
		end
	endtask

	task automatic field_check(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < REPORT_CAP)
				$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// predict on every byte beat, then check every token beat
	always @(posedge clk) begin
		lex_row_t d;
		res_t want;
		if (arst_n) begin
			if (bytes_ch.valid && bytes_ch.ready) begin
				d = pending_rows.pop_front();
				lex_byte(bytes_ch.ch, bytes_ch.is_last, !d.typed);
				if (d.typed && d.n > 0)
					expected_tokens.push_back(d.r0);
				if (d.typed && d.n > 1)
					expected_tokens.push_back(d.r1);
			end
			if (tok_ch.valid && tok_ch.ready) begin
				if (expected_tokens.size() == 0) begin
					if (mismatches < REPORT_CAP)
						$error("kind: expected none, got %0d", tok_ch.kind);
					mismatches++;
				end else begin
					want = expected_tokens.pop_front();
					field_check("kind", want.kind, tok_ch.kind);
					field_check("value", want.value, tok_ch.value);
					field_check("err_code", want.err_code, tok_ch.err_code);
					field_check("err_pos", want.err_pos, tok_ch.err_pos);
					field_check("final_res", want.final_res, tok_ch.final_res);
				end
			end
		end
	end

	// token sink with random stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			tok_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			stall_left = idle_len();
			tok_ch.ready <= (stall_left == 0);
		end
	end

	task automatic send_row(input lex_row_t r);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			bytes_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pending_rows.push_back(r);
		bytes_ch.valid <= 1'b1;
		bytes_ch.ch <= r.ch;
		bytes_ch.is_last <= r.last;
		@(posedge clk);
		while (!bytes_ch.ready) @(posedge clk);
	endtask

	// mostly well-formed regex with random content, noise mixed in
	task automatic gen_regex(input int len, input bit noisy);
		int gdepth;
		logic [7:0] gprev;
		logic gesc;
		logic [7:0] c;
		logic l;
		int r;
		gdepth = 0;
		gprev = '0;
		gesc = 1'b0;
		for (int i = 0; i < len; i++) begin
			l = (i == len - 1);
			r = $urandom_range(0, 99);
			if ((noisy && r < 25) || (!noisy && r < 2)) begin
				c = 8'($urandom_range(0, 255));
			end else if (gesc && r < 70) begin
				c = rand_word();
			end else if (gdepth > 0 && len - 1 - i <= gdepth && gprev != CH_UNION
				&& r < 90) begin
				c = CH_RPAREN;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45)
					c = rand_word();
				else if (r < 53)
					c = CH_STAR;
				else if (r < 59)
					c = CH_PLUS;
				else if (r < 65)
					c = CH_QUEST;
				else if (r < 75)
					c = CH_LPAREN;
				else if (r < 83)
					c = (gdepth > 0 && gprev != CH_UNION) ? CH_RPAREN : rand_word();
				else if (r < 91)
					c = (gprev != 0 && gprev != CH_LPAREN && gprev != CH_UNION)
						? CH_UNION : rand_word();
				else
					c = l ? rand_word() : CH_BSLASH;
			end
			if (c == CH_LPAREN)
				gdepth++;
			if (c == CH_RPAREN && gdepth > 0)
				gdepth--;
			if (c == CH_BSLASH)
				gesc = 1'b1;
			else if (!is_word(c))
				gesc = 1'b0;
			gprev = c;
			send_row(plain_row(c, l));
		end
	endtask

	initial begin
		int rand_sent;
		int len;
		logic [7:0] c;
		rand_sent = 0;
		lex_clear();
		arst_n <= 1'b0;
		bytes_ch.valid <= 1'b0;
		bytes_ch.ch <= '0;
		bytes_ch.is_last <= 1'b0;

		// single-byte regexes first, results typed in
		directed_rows.push_back(typed_row("a", 1'b1, 2'd2,
			tok(K_CHAR, "a", CODE_NONE, '0, 1'b0), tok(K_END, '0, CODE_NONE, '0, 1'b1)));
		directed_rows.push_back(typed_row(CH_RPAREN, 1'b1, 2'd1,
			tok(K_ERROR, '0, ERR_INVALID_CHAR, '0, 1'b1), NO_TOK));
		directed_rows.push_back(typed_row(CH_UNION, 1'b1, 2'd1,
			tok(K_ERROR, '0, ERR_INVALID_CHAR, '0, 1'b1), NO_TOK));
		directed_rows.push_back(typed_row(CH_BSLASH, 1'b1, 2'd1,
			tok(K_ERROR, '0, ERR_INVALID_ESC, '0, 1'b1), NO_TOK));
		directed_rows.push_back(typed_row(8'hFF, 1'b1, 2'd1,
			tok(K_ERROR, '0, ERR_INVALID_CHAR, '0, 1'b1), NO_TOK));
		directed_rows.push_back(typed_row(8'h00, 1'b1, 2'd1,
			tok(K_ERROR, '0, ERR_INVALID_CHAR, '0, 1'b1), NO_TOK));
		directed_rows.push_back(typed_row(CH_LPAREN, 1'b1, 2'd2,
			tok(K_LPAREN, CH_LPAREN, CODE_NONE, '0, 1'b0),
			tok(K_ERROR, '0, ERR_UNEXPECTED_END, 16'd1, 1'b1)));
		// every operator, escapes, empty escape, then a misplaced union
		directed_rows.push_back(plain_row(CH_LPAREN, 1'b0));
		directed_rows.push_back(plain_row("Z", 1'b0));
		directed_rows.push_back(plain_row(CH_STAR, 1'b0));
		directed_rows.push_back(plain_row(CH_UNION, 1'b0));
		directed_rows.push_back(plain_row("0", 1'b0));
		directed_rows.push_back(plain_row(CH_PLUS, 1'b0));
		directed_rows.push_back(plain_row(CH_RPAREN, 1'b0));
		directed_rows.push_back(plain_row(CH_QUEST, 1'b0));
		directed_rows.push_back(plain_row(CH_BSLASH, 1'b0));
		directed_rows.push_back(plain_row("9", 1'b0));
		directed_rows.push_back(plain_row("z", 1'b0));
		directed_rows.push_back(plain_row(CH_STAR, 1'b0));
		directed_rows.push_back(plain_row(CH_BSLASH, 1'b0));
		directed_rows.push_back(plain_row(CH_LPAREN, 1'b0));
		directed_rows.push_back(plain_row(CH_UNION, 1'b0));
		directed_rows.push_back(plain_row("q", 1'b0));
		directed_rows.push_back(plain_row("q", 1'b1));
		// union right before close paren, then union as the final byte
		directed_rows.push_back(plain_row("a", 1'b0));
		directed_rows.push_back(plain_row(CH_UNION, 1'b0));
		directed_rows.push_back(plain_row(CH_RPAREN, 1'b0));
		directed_rows.push_back(plain_row(CH_UNION, 1'b1));
		directed_rows.push_back(plain_row("b", 1'b0));
		directed_rows.push_back(plain_row(CH_UNION, 1'b1));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_row(directed_rows[i]);

		// depth overflow on the paren past the maximum
		repeat (MAX_DEPTH) send_row(plain_row(CH_LPAREN, 1'b0));
		send_row(plain_row(CH_LPAREN, 1'b0));
		send_row(plain_row("a", 1'b1));

		// long unclosed regex streamed without gaps
		calm = 1'b1;
		send_row(plain_row(CH_LPAREN, 1'b0));
		for (int i = 1; i < LONG_BYTES; i++) begin
			c = (i != LONG_BYTES - 1 && $urandom_range(0, 3) == 0) ? CH_STAR : rand_word();
			send_row(plain_row(c, i == LONG_BYTES - 1));
		end
		calm = 1'b0;

		while (rand_sent < RANDOM_BYTES) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			calm = ($urandom_range(0, 7) == 0);
			gen_regex(len, $urandom_range(0, 4) == 0);
			rand_sent += len;
		end
		calm = 1'b0;
		bytes_ch.valid <= 1'b0;

		while (expected_tokens.size() != 0 || pending_rows.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
